/* src/rpf_pkg.sv */
// Package for the RGB565 packet framer: result record, kind codes and packet constants.
// Used by src/rgb565_packet_framer.sv, sim/rpf_checker.sv and sim/testbench.sv; depends on nothing else.
package rpf_pkg;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_INIT  = 2'd1,
    KIND_DATA  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] pixel_word;
    logic [15:0] checksum;
    logic [9:0]  packet_length;
    logic [7:0]  command_code;
    logic [14:0] byte_offset;
    logic        last;
  } result_t;

  localparam int unsigned MaxFramePixels = 16384;
  localparam int unsigned MaxChunkBytes  = 1012;
  localparam int unsigned MaxChunkPixels = MaxChunkBytes / 2;

  localparam int unsigned FrameCfgW = 15;
  localparam int unsigned ChunkCfgW = 9;
  localparam int unsigned PosW      = 14;
  localparam int unsigned FillW     = 9;

  localparam logic [FrameCfgW-1:0] FrameMax = FrameCfgW'(MaxFramePixels);
  localparam logic [ChunkCfgW-1:0] ChunkMax = ChunkCfgW'(MaxChunkPixels);

  localparam logic [FrameCfgW-1:0] FramePixelsRst = 15'd12800;
  localparam logic [ChunkCfgW-1:0] ChunkPixelsRst = 9'd506;

  localparam logic [15:0] HdrWord  = 16'h0422;
  localparam logic [7:0]  CmdInit  = 8'h3E;
  localparam logic [7:0]  CmdData  = 8'h25;
  localparam logic [9:0]  InitLen  = 10'd9;
  localparam logic [15:0] InitSum  = 16'h046A;
  localparam logic [9:0]  HdrBytes = 10'd8;

  // Configuration register indexes.
  localparam logic REG_FRAME_PIXELS = 1'b0;
  localparam logic REG_CHUNK_PIXELS = 1'b1;

  // Result queue.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

endpackage

/* src/rgb565_packet_framer.sv */
// RGB565 packet framer top level: pixel packing, chunk tracking, descriptor build, result queue.
// Depends on rpf_pkg.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+------------------------------------------
//  pixel in | input     | in_valid_i/in_ready_o  | first_byte_i, second_byte_i, third_byte_i
//  result   | output    | out_valid_o/out_ready_i| kind_o .. byte_offset_o, last_o
//  config   | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// A pixel request is packed and framed in the cycle it is accepted; its one or two results
// are written into a four-entry result queue and leave one per cycle from the queue head
// while the receiver is ready. The queue's single read port sets the rate: one pixel per
// cycle when each pixel gives one result, less for pixels that give two results.
// Input is taken while the queue holds two entries or fewer, so a stalled output stops
// intake after at most three further requests. Reset empties the queue and starts a new frame.
module rgb565_packet_framer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      first_byte_i,
  input  logic [7:0]                      second_byte_i,
  input  logic [7:0]                      third_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      kind_o,
  output logic [15:0]                     pixel_word_o,
  output logic [15:0]                     checksum_o,
  output logic [9:0]                      packet_length_o,
  output logic [7:0]                      command_code_o,
  output logic [14:0]                     byte_offset_o,
  output logic                            last_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [rpf_pkg::FrameCfgW-1:0]   cfg_data_i
);

  // Configuration.
  logic [rpf_pkg::FrameCfgW-1:0] frame_pixels_q;
  logic [rpf_pkg::ChunkCfgW-1:0] chunk_pixels_q;

  // Frame and chunk state.
  logic [rpf_pkg::PosW-1:0]  pos_q, pos_d;
  logic [rpf_pkg::FillW-1:0] fill_q, fill_d;
  logic [15:0]               sum_q, sum_d;
  logic [14:0]               offset_q, offset_d;

  // Result queue.
  rpf_pkg::result_t           queue_q [rpf_pkg::QDepth];
  logic [rpf_pkg::QPtrW-1:0]  wr_ptr_q, rd_ptr_q, wr_ptr_nxt;
  logic [rpf_pkg::QCntW-1:0]  count_q;

  logic                          in_fire, out_fire;
  logic [rpf_pkg::FrameCfgW-1:0] fsize;
  logic [rpf_pkg::ChunkCfgW-1:0] csize;
  logic [15:0]                   word, run_sum, chk;
  logic                          at_start, frame_end, chunk_end, two_results;
  logic [9:0]                    len;
  logic [14:0]                   offset_eff;
  rpf_pkg::result_t              res_a, res_b, res_word, res_init, res_data;

  assign in_ready_o  = (count_q <= rpf_pkg::QCntW'(rpf_pkg::QDepth - 2));
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;

  always_comb begin
    fsize = frame_pixels_q;
    if (fsize == '0) begin
      fsize = rpf_pkg::FrameCfgW'(1);
    end else if (fsize > rpf_pkg::FrameMax) begin
      fsize = rpf_pkg::FrameMax;
    end
    csize = chunk_pixels_q;
    if (csize == '0) begin
      csize = rpf_pkg::ChunkCfgW'(1);
    end else if (csize > rpf_pkg::ChunkMax) begin
      csize = rpf_pkg::ChunkMax;
    end
  end

  always_comb begin
    word       = {first_byte_i[7:3], second_byte_i[7:2], third_byte_i[7:3]};
    at_start   = (pos_q == '0);
    frame_end  = ({1'b0, pos_q} + rpf_pkg::FrameCfgW'(1)) >= fsize;
    chunk_end  = frame_end || (({1'b0, fill_q} + 10'd1) >= {1'b0, csize});
    offset_eff = (fill_q == '0) ? {pos_q, 1'b0} : offset_q;
    run_sum    = sum_q + word;
    len        = 10'(({1'b0, fill_q} + 10'd1) << 1) + rpf_pkg::HdrBytes;
    chk        = rpf_pkg::HdrWord + 16'(len) + 16'(rpf_pkg::CmdData) + 16'(offset_eff)
                 + run_sum;

    res_word               = '0;
    res_word.kind          = rpf_pkg::KIND_PIXEL;
    res_word.pixel_word    = word;
    res_word.last          = !chunk_end;

    res_init               = '0;
    res_init.kind          = rpf_pkg::KIND_INIT;
    res_init.checksum      = rpf_pkg::InitSum;
    res_init.packet_length = rpf_pkg::InitLen;
    res_init.command_code  = rpf_pkg::CmdInit;

    res_data               = '0;
    res_data.kind          = rpf_pkg::KIND_DATA;
    res_data.checksum      = chk;
    res_data.packet_length = len;
    res_data.command_code  = rpf_pkg::CmdData;
    res_data.byte_offset   = offset_eff;
    res_data.last          = 1'b1;

    // A one-pixel chunk at frame start would need three results; the init descriptor is dropped.
    two_results = chunk_end || at_start;
    if (at_start && !chunk_end) begin
      res_a = res_init;
      res_b = res_word;
    end else begin
      res_a = res_word;
      res_b = res_data;
    end

    offset_d = offset_eff;
    if (chunk_end) begin
      fill_d = '0;
      sum_d  = '0;
    end else begin
      fill_d = fill_q + rpf_pkg::FillW'(1);
      sum_d  = run_sum;
    end
    pos_d = frame_end ? '0 : pos_q + rpf_pkg::PosW'(1);

    wr_ptr_nxt = wr_ptr_q + rpf_pkg::QPtrW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pixels_q <= rpf_pkg::FramePixelsRst;
      chunk_pixels_q <= rpf_pkg::ChunkPixelsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rpf_pkg::REG_FRAME_PIXELS: frame_pixels_q <= cfg_data_i;
        rpf_pkg::REG_CHUNK_PIXELS: chunk_pixels_q <= cfg_data_i[rpf_pkg::ChunkCfgW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      fill_q   <= '0;
      sum_q    <= '0;
      offset_q <= '0;
    end else if (in_fire) begin
      pos_q    <= pos_d;
      fill_q   <= fill_d;
      sum_q    <= sum_d;
      offset_q <= offset_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      queue_q[wr_ptr_q] <= res_a;
      if (two_results) begin
        queue_q[wr_ptr_nxt] <= res_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= two_results ? wr_ptr_q + rpf_pkg::QPtrW'(2) : wr_ptr_nxt;
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + rpf_pkg::QPtrW'(1);
      end
      count_q <= count_q
                 + (in_fire ? (two_results ? rpf_pkg::QCntW'(2) : rpf_pkg::QCntW'(1)) : '0)
                 - (out_fire ? rpf_pkg::QCntW'(1) : '0);
    end
  end

  assign kind_o          = queue_q[rd_ptr_q].kind;
  assign pixel_word_o    = queue_q[rd_ptr_q].pixel_word;
  assign checksum_o      = queue_q[rd_ptr_q].checksum;
  assign packet_length_o = queue_q[rd_ptr_q].packet_length;
  assign command_code_o  = queue_q[rd_ptr_q].command_code;
  assign byte_offset_o   = queue_q[rd_ptr_q].byte_offset;
  assign last_o          = queue_q[rd_ptr_q].last;

  // The queue never holds more entries than it has slots.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rpf_pkg::QCntW'(rpf_pkg::QDepth))
    else $error("result queue overfilled");

  // An accepted request always leaves a result waiting in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted request produced no result");

  // A data descriptor always closes the results of its request.
  a_data_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == rpf_pkg::KIND_DATA) |-> last_o)
    else $error("data descriptor without last");

  // An init descriptor is always followed by a pixel word from the same request.
  a_init_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == rpf_pkg::KIND_INIT) |-> !last_o && count_q >= 2)
    else $error("init descriptor not followed by its pixel word");

endmodule

/* sim/rpf_checker.sv */
// Scoreboard for the RGB565 packet framer: watches the pixel, result and configuration ports,
// predicts every result from its own model of the framing state and compares field by field.
// Depends on rpf_pkg for the result record, kind codes, register indexes and packet constants.
`timescale 1ns / 1ps

module rpf_checker
  import rpf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [7:0]           first_byte_i,
  input  logic [7:0]           second_byte_i,
  input  logic [7:0]           third_byte_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [1:0]           kind_i,
  input  logic [15:0]          pixel_word_i,
  input  logic [15:0]          checksum_i,
  input  logic [9:0]           packet_length_i,
  input  logic [7:0]           command_code_i,
  input  logic [14:0]          byte_offset_i,
  input  logic                 last_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [FrameCfgW-1:0] cfg_data_i,
  output int unsigned          mismatches_o,
  output int unsigned          pending_o,
  output int unsigned          pixels_o,
  output int unsigned          descriptors_o
);

  logic [FrameCfgW-1:0] frame_pixels_q;
  logic [ChunkCfgW-1:0] chunk_pixels_q;
  logic [PosW-1:0]      position_q;
  logic [FillW-1:0]     fill_q;
  logic [15:0]          chunk_sum_q;
  logic [14:0]          chunk_offset_q;

  result_t awaited_results[$];
  result_t oldest;

  function automatic result_t make_result(input kind_e k, input logic [15:0] word,
                                          input logic [15:0] sum, input logic [9:0] len,
                                          input logic [7:0] cmd, input logic [14:0] off,
                                          input logic fin);
    result_t r;
    r.kind          = k;
    r.pixel_word    = word;
    r.checksum      = sum;
    r.packet_length = len;
    r.command_code  = cmd;
    r.byte_offset   = off;
    r.last          = fin;
    return r;
  endfunction

  // Packs one pixel, advances the frame and chunk state and queues the results it causes.
  function automatic void frame_pixel(input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2);
    int unsigned fsize;
    int unsigned csize;
    logic [15:0] word;
    logic [15:0] running;
    logic [15:0] chk;
    logic [9:0]  len;
    bit          at_start;
    bit          frame_end;
    bit          chunk_end;
    fsize = 32'(frame_pixels_q);
    csize = 32'(chunk_pixels_q);
    if (fsize == 0) fsize = 1;
    if (fsize > MaxFramePixels) fsize = MaxFramePixels;
    if (csize == 0) csize = 1;
    if (csize > MaxChunkPixels) csize = MaxChunkPixels;

    word      = {b0[7:3], b1[7:2], b2[7:3]};
    at_start  = (position_q == '0);
    frame_end = (int'(position_q) + 1 >= fsize);
    if (fill_q == '0) chunk_offset_q = {position_q, 1'b0};
    chunk_end = frame_end || (int'(fill_q) + 1 >= csize);

    // A pixel that opens and closes its chunk at once gets no init descriptor.
    if (at_start && !chunk_end)
      awaited_results.push_back(make_result(KIND_INIT, 16'h0, InitSum, InitLen, CmdInit,
                                            15'h0, 1'b0));
    running = chunk_sum_q + word;
    awaited_results.push_back(make_result(KIND_PIXEL, word, 16'h0, 10'h0, 8'h0, 15'h0,
                                          !chunk_end));
    if (chunk_end) begin
      len = 10'((int'(fill_q) + 1) * 2) + HdrBytes;
      chk = HdrWord + 16'(len) + 16'(CmdData) + 16'(chunk_offset_q) + running;
      awaited_results.push_back(make_result(KIND_DATA, 16'h0, chk, len, CmdData,
                                            chunk_offset_q, 1'b1));
      fill_q      = '0;
      chunk_sum_q = '0;
    end else begin
      fill_q      = fill_q + FillW'(1);
      chunk_sum_q = running;
    end
    position_q = frame_end ? '0 : position_q + PosW'(1);
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pixels_q = FramePixelsRst;
      chunk_pixels_q = ChunkPixelsRst;
      position_q     = '0;
      fill_q         = '0;
      chunk_sum_q    = '0;
      chunk_offset_q = '0;
      awaited_results.delete();
      mismatches_o   = 0;
      pixels_o       = 0;
      descriptors_o  = 0;
      pending_o     <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        frame_pixel(first_byte_i, second_byte_i, third_byte_i);
        pixels_o++;
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("result with nothing awaited: kind %0d, word 0x%0h", kind_i, pixel_word_i);
          mismatches_o++;
        end else begin
          oldest = awaited_results.pop_front();
          compare_field("kind", oldest.kind, kind_i);
          compare_field("pixel_word", oldest.pixel_word, pixel_word_i);
          compare_field("checksum", oldest.checksum, checksum_i);
          compare_field("packet_length", oldest.packet_length, packet_length_i);
          compare_field("command_code", oldest.command_code, command_code_i);
          compare_field("byte_offset", oldest.byte_offset, byte_offset_i);
          compare_field("last", oldest.last, last_i);
          if (oldest.kind != KIND_PIXEL) descriptors_o++;
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_FRAME_PIXELS) frame_pixels_q = cfg_data_i;
        else chunk_pixels_q = cfg_data_i[ChunkCfgW-1:0];
      end
      // Registered so that the stimulus side always sees the count settled at the last edge.
      pending_o <= awaited_results.size();
    end
  end

endmodule

/* sim/testbench.sv */
// Top of the RGB565 packet framer bench: clock, reset, pixel requests with bursts and gaps,
// a stalling receiver, configuration phases and the verdict. Depends on rpf_pkg, the block
// rgb565_packet_framer and the scoreboard rpf_checker.
`timescale 1ns / 1ps

module testbench;
  import rpf_pkg::*;

  localparam int unsigned TotalPixels = 850;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned CycleLimit = 200000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           first_byte_i = 8'h0;
  logic [7:0]           second_byte_i = 8'h0;
  logic [7:0]           third_byte_i = 8'h0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [1:0]           kind_o;
  logic [15:0]          pixel_word_o;
  logic [15:0]          checksum_o;
  logic [9:0]           packet_length_o;
  logic [7:0]           command_code_o;
  logic [14:0]          byte_offset_o;
  logic                 last_o;
  logic                 cfg_we_i = 1'b0;
  logic                 cfg_idx_i = 1'b0;
  logic [FrameCfgW-1:0] cfg_data_i = '0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned pixels_seen;
  int unsigned descriptors_seen;

  int unsigned cycles = 0;
  int unsigned pixels_sent = 0;
  int unsigned settings_used = 0;
  int unsigned burst_left = 0;
  bit          steady = 1'b0;

  logic [FrameCfgW-1:0] frame_val;
  logic [ChunkCfgW-1:0] chunk_val;
  int unsigned          which_regs;

  // Receiver stall pattern: a mode held for a random stretch, from always ready to mostly stalled.
  int unsigned sink_mode = 0;
  int unsigned sink_left = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  rgb565_packet_framer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .first_byte_i   (first_byte_i),
    .second_byte_i  (second_byte_i),
    .third_byte_i   (third_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .pixel_word_o   (pixel_word_o),
    .checksum_o     (checksum_o),
    .packet_length_o(packet_length_o),
    .command_code_o (command_code_o),
    .byte_offset_o  (byte_offset_o),
    .last_o         (last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  rpf_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .first_byte_i   (first_byte_i),
    .second_byte_i  (second_byte_i),
    .third_byte_i   (third_byte_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_i         (kind_o),
    .pixel_word_i   (pixel_word_o),
    .checksum_i     (checksum_o),
    .packet_length_i(packet_length_o),
    .command_code_i (command_code_o),
    .byte_offset_i  (byte_offset_o),
    .last_i         (last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .pixels_o       (pixels_seen),
    .descriptors_o  (descriptors_seen)
  );

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_mode   <= 0;
      sink_left   <= 0;
    end else begin
      if (sink_left == 0) begin
        sink_mode <= $urandom_range(0, 3);
        sink_left <= $urandom_range(8, 96);
      end else begin
        sink_left <= sink_left - 1;
      end
      case (sink_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= ~out_ready_i;
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $error("run stopped at the cycle limit with %0d results still awaited", pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // The pending count is registered, so the task lets it update before checking that it covers the last request.
  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic feed_pixel(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
    int unsigned gap;
    bit          hold;
    if (burst_left == 0) begin
      gap  = steady ? 0 : $urandom_range(0, 6);
      hold = !steady && ($urandom_range(0, 15) == 0);
      if (gap != 0 || hold) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        if (hold) wait_drained();
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    first_byte_i  <= b0;
    second_byte_i <= b1;
    third_byte_i  <= b2;
    do @(posedge clk_i); while (!in_ready_o);
    pixels_sent++;
  endtask

  task automatic feed_random(input int unsigned count);
    repeat (count) feed_pixel(rand_byte(), rand_byte(), rand_byte());
  endtask

  task automatic write_reg(input logic idx, input logic [FrameCfgW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Registers change only with the block idle; the framing state carries over between settings.
  task automatic configure(input logic [FrameCfgW-1:0] frame_data,
                           input logic [FrameCfgW-1:0] chunk_data, input int unsigned regs);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (regs != 3) write_reg(REG_FRAME_PIXELS, frame_data);
    if (regs != 2) write_reg(REG_CHUNK_PIXELS, chunk_data);
    cfg_we_i   <= 1'b0;
    burst_left  = 0;
    steady      = ($urandom_range(0, 3) == 0);
    settings_used++;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: colour extremes, only the kept bits set, then only the dropped bits set.
    feed_pixel(8'h00, 8'h00, 8'h00);
    feed_pixel(8'hFF, 8'hFF, 8'hFF);
    feed_pixel(8'hF8, 8'hFC, 8'hF8);
    feed_pixel(8'h07, 8'h03, 8'h07);
    // A frame size of zero acts as one pixel, so each pixel is a whole frame.
    configure(15'd0, 15'd506, 0);
    feed_random(2);
    configure(15'd1, 15'd0, 0);
    feed_random(1);
    // One-pixel chunks: every pixel closes its chunk and no init descriptor appears.
    configure(15'd5, 15'd1, 0);
    feed_random(2);
    // Oversized settings are clamped to the largest frame and chunk.
    configure(15'h7FFF, 15'd511, 0);
    feed_random(5);
    // Lowering the chunk size mid-chunk makes the next pixel close the overfull chunk.
    configure(15'h7FFF, 15'd2, 3);
    feed_random(1);
    // Lowering the frame size below the position makes the next pixel end the frame.
    configure(15'd3, 15'd2, 2);
    feed_random(2);
    configure(15'd7, 15'd3, 0);
    feed_random(7);

    while (pixels_sent < TotalPixels) begin
      case ($urandom_range(0, 15))
        0:       frame_val = 15'd0;
        1:       frame_val = 15'd1;
        2:       frame_val = 15'd2;
        3:       frame_val = 15'(MaxFramePixels);
        4:       frame_val = 15'(MaxFramePixels + 1);
        5:       frame_val = 15'h7FFF;
        6:       frame_val = 15'($urandom);
        default: frame_val = 15'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 15))
        0:       chunk_val = 9'd0;
        1:       chunk_val = 9'd1;
        2:       chunk_val = 9'(MaxChunkPixels - 1);
        3:       chunk_val = 9'(MaxChunkPixels);
        4:       chunk_val = 9'(MaxChunkPixels + 1);
        5:       chunk_val = 9'h1FF;
        6:       chunk_val = 9'($urandom);
        default: chunk_val = 9'($urandom_range(1, 12));
      endcase
      which_regs = $urandom_range(0, 3);
      // The upper data bits are ignored by the chunk register but are driven anyway.
      configure(frame_val, {6'($urandom), chunk_val}, which_regs);
      feed_random($urandom_range(6, 40));
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d pixel requests under %0d register settings.", pixels_sent, settings_used);
    $display("Checked %0d results, %0d of them packet descriptors.",
             pixels_seen + descriptors_seen, descriptors_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
